// File: rtl/sll_pkg.sv
`timescale 1ns / 1ps
// Shared types, token kinds, scan modes and helper functions for the lexer.
// Depends on nothing; every other file of the block imports it.
package sll_pkg;

    localparam int KW_MAX_LEN = 6;
    localparam int WORD_W     = 8 * KW_MAX_LEN;
    localparam int WL_W       = $clog2(KW_MAX_LEN + 2);
    localparam int KW_COUNT   = 14;
    localparam int RES_MAX    = 3;

    localparam logic [5:0] K_DOT        = 6'd8;
    localparam logic [5:0] K_SLASH      = 6'd11;
    localparam logic [5:0] K_AND        = 6'd14;
    localparam logic [5:0] K_AND_AND    = 6'd15;
    localparam logic [5:0] K_OR         = 6'd16;
    localparam logic [5:0] K_OR_OR      = 6'd17;
    localparam logic [5:0] K_BANG       = 6'd18;
    localparam logic [5:0] K_BANG_EQ    = 6'd19;
    localparam logic [5:0] K_EQ         = 6'd20;
    localparam logic [5:0] K_EQ_EQ      = 6'd21;
    localparam logic [5:0] K_LT         = 6'd22;
    localparam logic [5:0] K_LT_EQ      = 6'd23;
    localparam logic [5:0] K_SHL        = 6'd24;
    localparam logic [5:0] K_GT         = 6'd25;
    localparam logic [5:0] K_GT_EQ      = 6'd26;
    localparam logic [5:0] K_SHR        = 6'd27;
    localparam logic [5:0] K_NONE       = 6'd0;
    localparam logic [5:0] K_STRING     = 6'd28;
    localparam logic [5:0] K_NUMBER     = 6'd29;
    localparam logic [5:0] K_IDENT      = 6'd30;
    localparam logic [5:0] K_KEYWORD0   = 6'd31;
    localparam logic [5:0] K_EOF        = 6'd45;
    localparam logic [5:0] K_ERR_CHAR   = 6'd46;
    localparam logic [5:0] K_ERR_STRING = 6'd47;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OPTWO, M_NUMBER,
        M_NUMDOT, M_FRACTION, M_IDENT, M_STRING
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] line;
    } token_t;

    typedef struct packed {
        logic [1:0]   count;
        token_t [2:0] tok;
    } res_t;

    localparam logic [WORD_W-1:0] KW_TEXT [KW_COUNT] = '{
        WORD_W'("class"), WORD_W'("else"), WORD_W'("false"), WORD_W'("for"),
        WORD_W'("func"), WORD_W'("if"), WORD_W'("null"), WORD_W'("print"),
        WORD_W'("return"), WORD_W'("super"), WORD_W'("this"), WORD_W'("true"),
        WORD_W'("var"), WORD_W'("while")
    };
    localparam logic [WL_W-1:0] KW_LEN [KW_COUNT] = '{
        WL_W'(5), WL_W'(4), WL_W'(5), WL_W'(3), WL_W'(4), WL_W'(2), WL_W'(4),
        WL_W'(5), WL_W'(6), WL_W'(5), WL_W'(4), WL_W'(4), WL_W'(3), WL_W'(5)
    };

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic token_t mk_tok(input logic [5:0] kind, input logic [31:0] b,
                                      input logic [31:0] e, input logic has_len,
                                      input logic [31:0] line);
        token_t t;
        logic [31:0] d;
        d = e - b;
        t.kind  = kind;
        t.start = b;
        t.line  = line;
        if (!has_len || e <= b) t.len = 16'd0;
        else if (d > 32'h0000_FFFF) t.len = 16'hFFFF;
        else t.len = d[15:0];
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "&":     return K_AND;
            "|":     return K_OR;
            "!":     return K_BANG;
            "=":     return K_EQ;
            "<":     return K_LT;
            default: return K_GT;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] f, input logic [7:0] c);
        case (f)
            "&":     return (c == "&") ? K_AND_AND : K_NONE;
            "|":     return (c == "|") ? K_OR_OR : K_NONE;
            "!":     return (c == "=") ? K_BANG_EQ : K_NONE;
            "=":     return (c == "=") ? K_EQ_EQ : K_NONE;
            "<":     return (c == "=") ? K_LT_EQ : ((c == "<") ? K_SHL : K_NONE);
            ">":     return (c == "=") ? K_GT_EQ : ((c == ">") ? K_SHR : K_NONE);
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] word_kind(input logic [WORD_W-1:0] w,
                                             input logic [WL_W-1:0] n);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (KW_LEN[i] == n && KW_TEXT[i] == w) k = K_KEYWORD0 + 6'(i);
        end
        return k;
    endfunction

endpackage

// File: rtl/sll_scan.sv
`timescale 1ns / 1ps
// Scanner state registers and the single-pass next-state and token logic.
// Depends on sll_pkg.
module sll_scan (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    ch,
    input  logic          has_char,
    input  logic          end_of_source,
    output sll_pkg::res_t res
);
    import sll_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       begin_reg, begin_next;
    logic [31:0]       line_reg, line_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WL_W-1:0]   wlen_reg, wlen_next;
    logic [7:0]        held_reg, held_next;
    logic              quote_reg, quote_next;

    token_t     cand [6];
    logic [5:0] cand_v;
    logic [31:0] nx;
    logic        used;
    logic [5:0]  pk;
    logic [1:0]  n;

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        line_next  = line_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        held_next  = held_reg;
        quote_next = quote_reg;
        nx     = sat_inc(pos_reg);
        used   = 1'b1;
        pk     = pair_kind(held_reg, ch);
        cand_v = '0;
        for (int i = 0; i < 6; i++) cand[i] = '0;

        if (has_char) begin
            case (mode_reg)
                M_SLASH: begin
                    mode_next = M_IDLE;
                    if (ch == "/") mode_next = M_COMMENT;
                    else begin
                        cand[0] = mk_tok(K_SLASH, begin_reg, pos_reg, 1'b1, line_reg);
                        cand_v[0] = 1'b1;
                        used = 1'b0;
                    end
                end
                M_COMMENT: begin
                    if (ch == "\n") begin
                        mode_next = M_IDLE;
                        used = 1'b0;
                    end
                end
                M_OPTWO: begin
                    mode_next = M_IDLE;
                    cand_v[0] = 1'b1;
                    if (pk != K_NONE) begin
                        cand[0] = mk_tok(pk, begin_reg, nx, 1'b1, line_reg);
                    end else begin
                        cand[0] = mk_tok(single_kind(held_reg), begin_reg, pos_reg,
                                         1'b1, line_reg);
                        used = 1'b0;
                    end
                end
                M_NUMBER: begin
                    if (ch == ".") mode_next = M_NUMDOT;
                    else if (!is_digit(ch)) begin
                        cand[0] = mk_tok(K_NUMBER, begin_reg, pos_reg, 1'b1, line_reg);
                        cand_v[0] = 1'b1;
                        mode_next = M_IDLE;
                        used = 1'b0;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(ch)) mode_next = M_FRACTION;
                    else begin
                        cand[0] = mk_tok(K_NUMBER, begin_reg, pos_reg - 32'd1, 1'b1,
                                         line_reg);
                        cand[1] = mk_tok(K_DOT, pos_reg - 32'd1, pos_reg, 1'b1, line_reg);
                        cand_v[1:0] = 2'b11;
                        mode_next = M_IDLE;
                        used = 1'b0;
                    end
                end
                M_FRACTION: begin
                    if (!is_digit(ch)) begin
                        cand[0] = mk_tok(K_NUMBER, begin_reg, pos_reg, 1'b1, line_reg);
                        cand_v[0] = 1'b1;
                        mode_next = M_IDLE;
                        used = 1'b0;
                    end
                end
                M_IDENT: begin
                    if (is_digit(ch) || is_alpha(ch)) begin
                        if (wlen_reg < WL_W'(KW_MAX_LEN))
                            word_next = {word_reg[WORD_W-9:0], ch};
                        if (wlen_reg <= WL_W'(KW_MAX_LEN)) wlen_next = wlen_reg + WL_W'(1);
                    end else begin
                        cand[0] = mk_tok(word_kind(word_reg, wlen_reg), begin_reg, pos_reg,
                                         1'b1, line_reg);
                        cand_v[0] = 1'b1;
                        mode_next = M_IDLE;
                        used = 1'b0;
                    end
                end
                M_STRING: begin
                    if (ch == (quote_reg ? 8'h27 : 8'h22)) begin
                        cand[0] = mk_tok(K_STRING, begin_reg, nx, 1'b1, line_reg);
                        cand_v[0] = 1'b1;
                        mode_next = M_IDLE;
                    end else if (ch == "\n") begin
                        line_next = sat_inc(line_reg);
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                    used = 1'b0;
                end
            endcase

            if (!used) begin
                cand[2] = mk_tok(6'd0, pos_reg, nx, 1'b1, line_reg);
                case (ch)
                    " ", "\r", "\t": ;
                    "\n": line_next = sat_inc(line_reg);
                    "(": cand_v[2] = 1'b1;
                    ")": begin cand[2].kind = 6'd1;  cand_v[2] = 1'b1; end
                    "[": begin cand[2].kind = 6'd2;  cand_v[2] = 1'b1; end
                    "]": begin cand[2].kind = 6'd3;  cand_v[2] = 1'b1; end
                    "{": begin cand[2].kind = 6'd4;  cand_v[2] = 1'b1; end
                    "}": begin cand[2].kind = 6'd5;  cand_v[2] = 1'b1; end
                    ";": begin cand[2].kind = 6'd6;  cand_v[2] = 1'b1; end
                    ",": begin cand[2].kind = 6'd7;  cand_v[2] = 1'b1; end
                    ".": begin cand[2].kind = K_DOT; cand_v[2] = 1'b1; end
                    "-": begin cand[2].kind = 6'd9;  cand_v[2] = 1'b1; end
                    "+": begin cand[2].kind = 6'd10; cand_v[2] = 1'b1; end
                    "*": begin cand[2].kind = 6'd12; cand_v[2] = 1'b1; end
                    "^": begin cand[2].kind = 6'd13; cand_v[2] = 1'b1; end
                    "/": begin
                        mode_next = M_SLASH;
                        begin_next = pos_reg;
                    end
                    "&", "|", "!", "=", "<", ">": begin
                        mode_next = M_OPTWO;
                        held_next = ch;
                        begin_next = pos_reg;
                    end
                    8'h22, 8'h27: begin
                        mode_next = M_STRING;
                        quote_next = (ch == 8'h27);
                        begin_next = pos_reg;
                    end
                    default: begin
                        if (is_digit(ch)) begin
                            mode_next = M_NUMBER;
                            begin_next = pos_reg;
                        end else if (is_alpha(ch)) begin
                            mode_next = M_IDENT;
                            begin_next = pos_reg;
                            word_next = WORD_W'(ch);
                            wlen_next = WL_W'(1);
                        end else begin
                            cand[2] = mk_tok(K_ERR_CHAR, pos_reg, pos_reg, 1'b0, line_reg);
                            cand_v[2] = 1'b1;
                        end
                    end
                endcase
            end
            pos_next = nx;
        end

        if (end_of_source) begin
            case (mode_next)
                M_SLASH: begin
                    cand[3] = mk_tok(K_SLASH, begin_next, pos_next, 1'b1, line_next);
                    cand_v[3] = 1'b1;
                end
                M_OPTWO: begin
                    cand[3] = mk_tok(single_kind(held_next), begin_next, pos_next, 1'b1,
                                     line_next);
                    cand_v[3] = 1'b1;
                end
                M_NUMBER, M_FRACTION: begin
                    cand[3] = mk_tok(K_NUMBER, begin_next, pos_next, 1'b1, line_next);
                    cand_v[3] = 1'b1;
                end
                M_NUMDOT: begin
                    cand[3] = mk_tok(K_NUMBER, begin_next, pos_next - 32'd1, 1'b1,
                                     line_next);
                    cand[4] = mk_tok(K_DOT, pos_next - 32'd1, pos_next, 1'b1, line_next);
                    cand_v[4:3] = 2'b11;
                end
                M_IDENT: begin
                    cand[3] = mk_tok(word_kind(word_next, wlen_next), begin_next, pos_next,
                                     1'b1, line_next);
                    cand_v[3] = 1'b1;
                end
                M_STRING: begin
                    cand[3] = mk_tok(K_ERR_STRING, begin_next, begin_next, 1'b0, line_next);
                    cand_v[3] = 1'b1;
                end
                default: ;
            endcase
            cand[5] = mk_tok(K_EOF, pos_next, pos_next, 1'b0, line_next);
            cand_v[5] = 1'b1;
            mode_next  = M_IDLE;
            pos_next   = '0;
            begin_next = '0;
            line_next  = 32'd1;
            word_next  = '0;
            wlen_next  = '0;
            held_next  = '0;
            quote_next = 1'b0;
        end

        // Pack the candidate tokens in order into the first three slots.
        res = '0;
        n = '0;
        for (int i = 0; i < 6; i++) begin
            if (cand_v[i] && res.count != 2'd3) begin
                res.tok[n] = cand[i];
                n = n + 2'd1;
                res.count = res.count + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            line_reg  <= 32'd1;
            word_reg  <= '0;
            wlen_reg  <= '0;
            held_reg  <= '0;
            quote_reg <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            line_reg  <= line_next;
            word_reg  <= word_next;
            wlen_reg  <= wlen_next;
            held_reg  <= held_next;
            quote_reg <= quote_next;
        end
    end

endmodule

// File: rtl/sll_outbuf.sv
`timescale 1ns / 1ps
// Result register holding up to three tokens of one item, sent one per request.
// Depends on sll_pkg.
module sll_outbuf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  sll_pkg::res_t res,
    output logic          can_load,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [5:0]    m_kind,
    output logic [31:0]   m_start_offset,
    output logic [15:0]   m_length,
    output logic [31:0]   m_line_no,
    output logic          m_last
);
    import sll_pkg::*;

    token_t [2:0] buf_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   idx_reg;
    token_t       cur;

    assign cur            = buf_reg[idx_reg];
    assign m_valid        = (cnt_reg != 2'd0);
    assign m_last         = (cnt_reg == 2'd1);
    assign m_kind         = cur.kind;
    assign m_start_offset = cur.start;
    assign m_length       = cur.len;
    assign m_line_no      = cur.line;
    assign can_load       = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= res.count;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) buf_reg <= res.tok;
    end

endmodule

// File: rtl/script_language_lexer_top.sv
`timescale 1ns / 1ps
// Top level of the streaming lexer: input register, scanner and result register.
// Depends on sll_pkg, sll_scan and sll_outbuf.
//
// Usage: each request on the s_ channel carries one source byte (s_ch with
// s_has_char high) and/or an end mark (s_end_of_source). Tokens leave on the
// m_ channel, one per request, with kind, start offset, length and the line
// count at the token's end; m_last marks the final token caused by one input.
// An input request first lands in an input register. When the result register
// can take its tokens, the scanner consumes it in a single pass and writes up
// to three tokens into the result register. Throughput is one byte per cycle
// while each byte yields at most one token and the receiver keeps m_ready
// high; an input yielding k tokens holds the result register until all k are
// taken, which is what bounds the rate. When the receiver stalls, the result
// register and then the input register fill up and s_ready drops; nothing is
// lost. An end mark flushes any pending token, sends Eof if a result slot
// is free and returns the scanner to its start state. Synchronous active-low
// reset clears all control state; the line count restarts at one.
module script_language_lexer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_has_char,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_kind,
    output logic [31:0] m_start_offset,
    output logic [15:0] m_length,
    output logic [31:0] m_line_no,
    output logic        m_last
);
    import sll_pkg::*;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       has_reg;
    logic       eos_reg;
    logic       advance;
    logic       can_load;
    res_t       res;

    // The held input moves into the scanner whenever the result register can
    // take all of its tokens in the same edge.
    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_ch;
            has_reg <= s_has_char;
            eos_reg <= s_end_of_source;
        end
    end

    sll_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .ch            (ch_reg),
        .has_char      (has_reg),
        .end_of_source (eos_reg),
        .res           (res)
    );

    sll_outbuf u_outbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance),
        .res            (res),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_start_offset (m_start_offset),
        .m_length       (m_length),
        .m_line_no      (m_line_no),
        .m_last         (m_last)
    );

`ifndef SYNTH
    // Reset leaves no token pending on the output.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Backpressure only comes from a held input that cannot move on.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && !can_load))
        else $error("input stalled without cause");

    // A token that is not the last of its group is followed by another one.
    a_group_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("token group cut short");
`endif

endmodule

// File: tb/script_language_lexer_top_tb.sv
`timescale 1ns / 1ps
// Testbench for script_language_lexer_top: feeds random and hand-picked source
// text as byte requests and checks every token against its own scanner model.
// Depends on sll_pkg and the lexer RTL.
module script_language_lexer_top_tb;
    import sll_pkg::*;

    // Punctuator kinds that the package does not name.
    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACK = 6'd2;
    localparam logic [5:0] K_RBRACK = 6'd3;
    localparam logic [5:0] K_LBRACE = 6'd4;
    localparam logic [5:0] K_RBRACE = 6'd5;
    localparam logic [5:0] K_SEMI   = 6'd6;
    localparam logic [5:0] K_COMMA  = 6'd7;
    localparam logic [5:0] K_MINUS  = 6'd9;
    localparam logic [5:0] K_PLUS   = 6'd10;
    localparam logic [5:0] K_STAR   = 6'd12;
    localparam logic [5:0] K_CARET  = 6'd13;

    // Idling phases: none, sender idle, receiver stalling, both lightly.
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    localparam int ITEM_TARGET = 270;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] ch;
        logic       has_char;
        logic       eos;
        int         phase;
    } source_req_t;

    typedef struct {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [31:0] line;
        logic        last;
    } token_due_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = 8'd0;
    logic        s_has_char = 1'b0;
    logic        s_end_of_source = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_kind;
    logic [31:0] m_start_offset;
    logic [15:0] m_length;
    logic [31:0] m_line_no;
    logic        m_last;

    script_language_lexer_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_has_char     (s_has_char),
        .s_end_of_source(s_end_of_source),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_start_offset (m_start_offset),
        .m_length       (m_length),
        .m_line_no      (m_line_no),
        .m_last         (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model. It mirrors the lexer state and turns each accepted
    // request into the tokens it should produce, at most three of them.
    // ------------------------------------------------------------------
    mode_t           scan_mode;
    logic [31:0]     src_pos;
    logic [31:0]     tok_begin;
    logic [31:0]     line_cnt;
    logic [WORD_W-1:0] word_bits;
    logic [WL_W-1:0] word_len;
    logic [7:0]      held_op;
    logic            single_quote;

    token_due_t tokens_due[$];
    int         step_tokens;
    int         error_count = 0;
    int         tokens_seen = 0;
    int         reqs_accepted = 0;
    int         sources_built = 0;

    string kw_words[KW_COUNT] = '{"class", "else", "false", "for", "func", "if", "null",
                                  "print", "return", "super", "this", "true", "var",
                                  "while"};

    task automatic clear_scanner();
        scan_mode    = M_IDLE;
        src_pos      = 32'd0;
        tok_begin    = 32'd0;
        line_cnt     = 32'd1;
        word_bits    = '0;
        word_len     = '0;
        held_op      = 8'd0;
        single_quote = 1'b0;
    endtask

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Queues one expected token; anything beyond the third of a step is lost.
    task automatic push_token(input logic [5:0] kind, input logic [31:0] b,
                              input logic [31:0] e, input logic has_len);
        token_due_t t;
        if (step_tokens >= RES_MAX) return;
        t.kind  = kind;
        t.start = b;
        t.line  = line_cnt;
        t.last  = 1'b0;
        if (has_len && e > b) t.len = (e - b > 32'h0000_FFFF) ? 16'hFFFF : 16'(e - b);
        else t.len = 16'd0;
        tokens_due.push_back(t);
        step_tokens++;
    endtask

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Keywords only match when the whole word was kept in word_bits.
    function automatic logic [5:0] classify_word();
        logic [63:0] packed_kw;
        for (int k = 0; k < KW_COUNT; k++) begin
            packed_kw = 64'd0;
            for (int n = 0; n < kw_words[k].len(); n++)
                packed_kw = (packed_kw << 8) | 64'(kw_words[k][n]);
            if (kw_words[k].len() <= KW_MAX_LEN && kw_words[k].len() == int'(word_len)
                && packed_kw == 64'(word_bits))
                return K_KEYWORD0 + 6'(k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [5:0] lone_op(input logic [7:0] c);
        case (c)
            "&":     return K_AND;
            "|":     return K_OR;
            "!":     return K_BANG;
            "=":     return K_EQ;
            "<":     return K_LT;
            default: return K_GT;
        endcase
    endfunction

    function automatic logic [5:0] joined_op(input logic [7:0] f, input logic [7:0] c);
        case (f)
            "&":     return (c == "&") ? K_AND_AND : K_NONE;
            "|":     return (c == "|") ? K_OR_OR : K_NONE;
            "!":     return (c == "=") ? K_BANG_EQ : K_NONE;
            "=":     return (c == "=") ? K_EQ_EQ : K_NONE;
            "<":     return (c == "=") ? K_LT_EQ : ((c == "<") ? K_SHL : K_NONE);
            ">":     return (c == "=") ? K_GT_EQ : ((c == ">") ? K_SHR : K_NONE);
            default: return K_NONE;
        endcase
    endfunction

    // A byte seen between tokens either is a whole token or opens one.
    task automatic start_token(input logic [7:0] c, input logic [31:0] nxt);
        case (c)
            " ", "\r", "\t": ;
            "\n": line_cnt = bump(line_cnt);
            "(": push_token(K_LPAREN, src_pos, nxt, 1'b1);
            ")": push_token(K_RPAREN, src_pos, nxt, 1'b1);
            "[": push_token(K_LBRACK, src_pos, nxt, 1'b1);
            "]": push_token(K_RBRACK, src_pos, nxt, 1'b1);
            "{": push_token(K_LBRACE, src_pos, nxt, 1'b1);
            "}": push_token(K_RBRACE, src_pos, nxt, 1'b1);
            ";": push_token(K_SEMI, src_pos, nxt, 1'b1);
            ",": push_token(K_COMMA, src_pos, nxt, 1'b1);
            ".": push_token(K_DOT, src_pos, nxt, 1'b1);
            "-": push_token(K_MINUS, src_pos, nxt, 1'b1);
            "+": push_token(K_PLUS, src_pos, nxt, 1'b1);
            "*": push_token(K_STAR, src_pos, nxt, 1'b1);
            "^": push_token(K_CARET, src_pos, nxt, 1'b1);
            "/": begin
                scan_mode = M_SLASH;
                tok_begin = src_pos;
            end
            "&", "|", "!", "=", "<", ">": begin
                scan_mode = M_OPTWO;
                held_op   = c;
                tok_begin = src_pos;
            end
            "\"", "'": begin
                scan_mode    = M_STRING;
                single_quote = (c == "'");
                tok_begin    = src_pos;
            end
            default: begin
                if (digit_byte(c)) begin
                    scan_mode = M_NUMBER;
                    tok_begin = src_pos;
                end else if (letter_byte(c)) begin
                    scan_mode = M_IDENT;
                    tok_begin = src_pos;
                    word_bits = WORD_W'(c);
                    word_len  = WL_W'(1);
                end else begin
                    push_token(K_ERR_CHAR, src_pos, src_pos, 1'b0);
                end
            end
        endcase
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic [31:0] nxt;
        logic        consumed;
        logic [5:0]  k;
        nxt = bump(src_pos);
        consumed = 1'b1;
        case (scan_mode)
            M_SLASH: begin
                scan_mode = M_IDLE;
                if (c == "/") scan_mode = M_COMMENT;
                else begin
                    push_token(K_SLASH, tok_begin, src_pos, 1'b1);
                    consumed = 1'b0;
                end
            end
            M_COMMENT: begin
                if (c == "\n") begin
                    scan_mode = M_IDLE;
                    consumed = 1'b0;
                end
            end
            M_OPTWO: begin
                scan_mode = M_IDLE;
                k = joined_op(held_op, c);
                if (k != K_NONE) push_token(k, tok_begin, nxt, 1'b1);
                else begin
                    push_token(lone_op(held_op), tok_begin, src_pos, 1'b1);
                    consumed = 1'b0;
                end
            end
            M_NUMBER: begin
                if (c == ".") scan_mode = M_NUMDOT;
                else if (!digit_byte(c)) begin
                    push_token(K_NUMBER, tok_begin, src_pos, 1'b1);
                    scan_mode = M_IDLE;
                    consumed = 1'b0;
                end
            end
            M_NUMDOT: begin
                // A dot after a number belongs to it only if a digit follows.
                if (digit_byte(c)) scan_mode = M_FRACTION;
                else begin
                    push_token(K_NUMBER, tok_begin, src_pos - 32'd1, 1'b1);
                    push_token(K_DOT, src_pos - 32'd1, src_pos, 1'b1);
                    scan_mode = M_IDLE;
                    consumed = 1'b0;
                end
            end
            M_FRACTION: begin
                if (!digit_byte(c)) begin
                    push_token(K_NUMBER, tok_begin, src_pos, 1'b1);
                    scan_mode = M_IDLE;
                    consumed = 1'b0;
                end
            end
            M_IDENT: begin
                if (digit_byte(c) || letter_byte(c)) begin
                    if (word_len < KW_MAX_LEN) word_bits = (word_bits << 8) | WORD_W'(c);
                    if (word_len <= KW_MAX_LEN) word_len = word_len + WL_W'(1);
                end else begin
                    push_token(classify_word(), tok_begin, src_pos, 1'b1);
                    scan_mode = M_IDLE;
                    consumed = 1'b0;
                end
            end
            M_STRING: begin
                if (c == (single_quote ? "'" : "\"")) begin
                    push_token(K_STRING, tok_begin, nxt, 1'b1);
                    scan_mode = M_IDLE;
                end else if (c == "\n") begin
                    line_cnt = bump(line_cnt);
                end
            end
            default: begin
                scan_mode = M_IDLE;
                consumed = 1'b0;
            end
        endcase
        if (!consumed) start_token(c, nxt);
        src_pos = nxt;
    endtask

    task automatic close_source();
        case (scan_mode)
            M_SLASH:  push_token(K_SLASH, tok_begin, src_pos, 1'b1);
            M_OPTWO:  push_token(lone_op(held_op), tok_begin, src_pos, 1'b1);
            M_NUMBER, M_FRACTION: push_token(K_NUMBER, tok_begin, src_pos, 1'b1);
            M_NUMDOT: begin
                push_token(K_NUMBER, tok_begin, src_pos - 32'd1, 1'b1);
                push_token(K_DOT, src_pos - 32'd1, src_pos, 1'b1);
            end
            M_IDENT:  push_token(classify_word(), tok_begin, src_pos, 1'b1);
            M_STRING: push_token(K_ERR_STRING, tok_begin, tok_begin, 1'b0);
            default: ;
        endcase
        push_token(K_EOF, src_pos, src_pos, 1'b0);
    endtask

    task automatic predict_tokens(input source_req_t r);
        step_tokens = 0;
        if (r.has_char) scan_byte(r.ch);
        if (r.eos) begin
            close_source();
            clear_scanner();
        end
        if (step_tokens > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    source_req_t pending_reqs[$];
    int          build_phase = PH_NONE;

    task automatic add_req(input logic [7:0] c, input logic hc, input logic e);
        source_req_t r;
        r.ch = c;
        r.has_char = hc;
        r.eos = e;
        r.phase = build_phase;
        pending_reqs.push_back(r);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_req(s[i], 1'b1, 1'b0);
    endtask

    function automatic string random_word();
        string w;
        int    n;
        w = "";
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(2))
                0: w = {w, string'(8'($urandom_range("a", "z")))};
                1: w = (i == 0) ? {w, "Q"} : {w, string'(8'($urandom_range("0", "9")))};
                default: w = {w, string'(8'($urandom_range("A", "Z")))};
            endcase
        end
        return w;
    endfunction

    function automatic string random_lexeme();
        string punct[22] = '{"(", ")", "[", "]", "{", "}", ";", ",", ".", "-", "+", "/",
                             "*", "^", "&", "|", "!", "=", "<", ">", "&&", "||"};
        string ops[8] = '{"!=", "==", "<=", "<<", ">=", ">>", "//x y\n", "\n"};
        string stretched[4] = '{"classes", "printer", "returned", "whiles"};
        string body;
        case ($urandom_range(11))
            0, 1:  return punct[$urandom_range(21)];
            2:     return ops[$urandom_range(7)];
            3:     return kw_words[$urandom_range(KW_COUNT - 1)];
            4:     return random_word();
            5:     return stretched[$urandom_range(3)];
            6:     return $sformatf("%0d", $urandom_range(999));
            7:     return $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
            8:     return $sformatf("%0d.", $urandom_range(9));
            9: begin
                body = ($urandom_range(3) == 0) ? "a\nb" : random_word();
                return $urandom_range(1) ? {"\"", body, "\""} : {"'", body, "'"};
            end
            10:    return string'(8'($urandom_range(255)));
            default: return ($urandom_range(1) ? " " : "\t\r");
        endcase
    endfunction

    // One random source: lexemes separated now and then by blanks,
    // closed by an end mark riding on the last byte or sent bare.
    task automatic add_source();
        int    n;
        string s;
        n = $urandom_range(1, 8);
        s = "";
        for (int i = 0; i < n; i++) begin
            s = {s, random_lexeme()};
            if ($urandom_range(2) == 0) s = {s, " "};
        end
        if ($urandom_range(4) == 0) s = {s, "\"open"};
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(19) == 0) add_req(8'($urandom), 1'b0, 1'b0);
            add_req(s[i], 1'b1, (i == s.len() - 1) && $urandom_range(1));
        end
        if (!pending_reqs[pending_reqs.size() - 1].eos) add_req(8'($urandom), 1'b0, 1'b1);
        sources_built++;
    endtask

    // ------------------------------------------------------------------
    // Driver: one request per handshake, gaps drawn per phase.
    // ------------------------------------------------------------------
    int recv_phase = PH_NONE;

    function automatic int idle_pct_send(input int ph);
        return (ph == PH_SEND) ? 65 : ((ph == PH_BOTH) ? 10 : 0);
    endfunction

    function automatic int idle_pct_recv(input int ph);
        return (ph == PH_RECV) ? 65 : ((ph == PH_BOTH) ? 10 : 0);
    endfunction

    source_req_t on_wire;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(on_wire);
                reqs_accepted <= reqs_accepted + 1;
                recv_phase <= on_wire.phase;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= idle_pct_send(pending_reqs[0].phase)) begin
                    on_wire = pending_reqs.pop_front();
                    s_valid         <= 1'b1;
                    s_ch            <= on_wire.ch;
                    s_has_char      <= on_wire.has_char;
                    s_end_of_source <= on_wire.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // A single long receiver hold-off partway through, so that the result
    // register and the input register both fill and s_ready goes low.
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct_recv(recv_phase));
    end

    // ------------------------------------------------------------------
    // Monitor: each token taken is compared with the oldest one due.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        $display("MISMATCH token %0d %s: expected %0d, got %0d", tokens_seen, what, want, got);
    endtask

    always @(posedge aclk) begin
        token_due_t t;
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                report_mismatch("with nothing due, kind", -1, m_kind);
            end else begin
                t = tokens_due.pop_front();
                if (m_kind !== t.kind) report_mismatch("kind", t.kind, m_kind);
                if (m_start_offset !== t.start) report_mismatch("start", t.start, m_start_offset);
                if (m_length !== t.len) report_mismatch("length", t.len, m_length);
                if (m_line_no !== t.line) report_mismatch("line", t.line, m_line_no);
                if (m_last !== t.last) report_mismatch("last", t.last, m_last);
            end
            tokens_seen++;
        end
    end

    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        clear_scanner();
        // Directed part: a number with a dead dot then a plus and the end
        // mark (four tokens, so Eof is dropped), a number ending in a dot at
        // the end mark, an unterminated string, a comment with a bare item
        // inside, a high byte, an underscore, two-character operators.
        add_text("1.");
        add_req("+", 1'b1, 1'b1);
        add_text("7.");
        add_req(8'd0, 1'b0, 1'b1);
        add_text("'a\n");
        add_req("b", 1'b1, 1'b1);
        add_text("//c");
        add_req(8'd0, 1'b0, 1'b0);
        add_req("\n", 1'b1, 1'b0);
        add_req(8'hFF, 1'b1, 1'b0);
        add_req(8'h00, 1'b1, 1'b0);
        add_text("_<=>>");
        add_req("x", 1'b1, 1'b1);
        add_req(8'd0, 1'b0, 1'b1);
        // Random sources over four idling phases.
        while (pending_reqs.size() < ITEM_TARGET) begin
            build_phase = (pending_reqs.size() * 4) / ITEM_TARGET;
            add_source();
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (tokens_due.size() == 0);
        repeat (20) @(posedge aclk);

        $display("Ran %0d requests in %0d random sources plus directed cases, %0d tokens.",
                 reqs_accepted, sources_built, tokens_seen);
        if (error_count == 0 && tokens_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
